### rtl/uv_sphere_mesh_generator_top_assert.svh
// Assertion macros used by the UV sphere generator checker.
`ifndef UV_SPHERE_MESH_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define UVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uv sphere check failed");

// Check a consequence in the cycle after its condition.
`define UVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uv sphere check failed");

`endif

### rtl/uvs_pkg.sv
// Shared types, constants and tables of the UV sphere mesh generator.
`timescale 1ns / 1ps

package uvs_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RINGS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SECTORS = 2'd2;
    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [7:0]  RINGS_RST   = 8'd16;
    localparam logic [7:0]  SECTORS_RST = 8'd32;

    // Request kinds
    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_CELL   = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 184;

    // Long divider: one quotient bit per step, eight steps per stage
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_BITS   = 8;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

    // CORDIC
    localparam int CORDIC_PER_STAGE = 4;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    // Per-item control that rides beside the arithmetic
    typedef struct packed {
        logic        kind;
        logic        tri_a_en;
        logic        tri_b_en;
        logic [15:0] k1;
        logic [15:0] k2;
    } side_t;

    typedef struct packed {
        logic [15:0] tex_s;
        logic [15:0] tex_t;
    } tex_t;

    // One result item
    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic [15:0] tri_first;
        logic [15:0] tri_second;
        logic [15:0] tri_third;
        logic        last;
    } res_t;

    // Control from the last arithmetic stage to the output unit
    typedef struct packed {
        logic valid;
        logic two;
    } out_ctl_t;

    // Arctangent of 2^-k in binary turns, 2^32 per turn
    function automatic logic [29:0] atan_turn(input int unsigned k);
        logic [29:0] a;
        case (k)
            0:  a = 30'd536870912;
            1:  a = 30'd316933406;
            2:  a = 30'd167458907;
            3:  a = 30'd85004756;
            4:  a = 30'd42667331;
            5:  a = 30'd21354465;
            6:  a = 30'd10679838;
            7:  a = 30'd5340245;
            8:  a = 30'd2670163;
            9:  a = 30'd1335087;
            10: a = 30'd667544;
            11: a = 30'd333772;
            12: a = 30'd166886;
            13: a = 30'd83443;
            14: a = 30'd41722;
            15: a = 30'd20861;
            16: a = 30'd10430;
            17: a = 30'd5215;
            18: a = 30'd2608;
            19: a = 30'd1304;
            20: a = 30'd652;
            21: a = 30'd326;
            22: a = 30'd163;
            23: a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/uvs_div.sv
// Pipelined restoring divider: 40-bit numerator by 8-bit divisor.
`timescale 1ns / 1ps

module uvs_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [7:0]                     divisor,
    input  logic [uvs_pkg::DIV_NUM_W-1:0]  num,
    output logic [uvs_pkg::DIV_NUM_W-1:0]  quot
);

    localparam int NW = uvs_pkg::DIV_NUM_W;
    localparam int NS = uvs_pkg::DIV_STAGES;

    logic [NW-1:0] acc_reg [NS];
    logic [7:0]    rem_reg [NS];

    for (genvar st = 0; st < NS; st++) begin : g_st
        logic [NW-1:0] acc_in;
        logic [NW-1:0] acc_next;
        logic [7:0]    rem_in;
        logic [7:0]    rem_next;

        if (st == 0) begin : g_first
            assign acc_in = num;
            assign rem_in = '0;
        end else begin : g_rest
            assign acc_in = acc_reg[st-1];
            assign rem_in = rem_reg[st-1];
        end

        // Shift in numerator bits, shift out quotient bits
        always_comb
        begin
            logic [8:0] trial;
            acc_next = acc_in;
            rem_next = rem_in;
            for (int b = 0; b < uvs_pkg::DIV_BITS; b++)
            begin
                trial    = {rem_next, acc_next[NW-1]};
                acc_next = {acc_next[NW-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    trial       = trial - {1'b0, divisor};
                    acc_next[0] = 1'b1;
                end
                rem_next = trial[7:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[st] <= acc_next;
                rem_reg[st] <= rem_next;
            end
        end
    end

    assign quot = acc_reg[NS-1];

endmodule

### rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
`timescale 1ns / 1ps

module uvs_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int PER    = uvs_pkg::CORDIC_PER_STAGE;
    localparam int STAGES = (STEPS + PER - 1) / PER;

    logic signed [31:0] x_reg [STAGES];
    logic signed [31:0] y_reg [STAGES];
    logic signed [31:0] z_reg [STAGES];
    logic [1:0]         q_reg [STAGES];

    for (genvar st = 0; st < STAGES; st++) begin : g_st
        logic signed [31:0] x_in, y_in, z_in;
        logic [1:0]         q_in;
        logic signed [31:0] x_next, y_next, z_next;

        if (st == 0) begin : g_first
            assign x_in = uvs_pkg::CORDIC_X0;
            assign y_in = '0;
            assign z_in = $signed({2'b00, phase[29:0]});
            assign q_in = phase[31:30];
        end else begin : g_rest
            assign x_in = x_reg[st-1];
            assign y_in = y_reg[st-1];
            assign z_in = z_reg[st-1];
            assign q_in = q_reg[st-1];
        end

        // Rotate toward zero residual angle
        always_comb
        begin
            logic signed [31:0] dx, dy, da;
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
            for (int b = 0; b < PER; b++)
            begin
                if (st * PER + b < STEPS)
                begin
                    dx = y_next >>> (st * PER + b);
                    dy = x_next >>> (st * PER + b);
                    da = $signed({2'b00, uvs_pkg::atan_turn(st * PER + b)});
                    if (!z_next[31])
                    begin
                        x_next = x_next - dx;
                        y_next = y_next + dy;
                        z_next = z_next - da;
                    end
                    else
                    begin
                        x_next = x_next + dx;
                        y_next = y_next - dy;
                        z_next = z_next + da;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[st] <= x_next;
                y_reg[st] <= y_next;
                z_reg[st] <= z_next;
                q_reg[st] <= q_in;
            end
        end
    end

    // Restore the quadrant
    always_comb
    begin
        case (q_reg[STAGES-1])
            2'd0:
            begin
                cos_out = x_reg[STAGES-1];
                sin_out = y_reg[STAGES-1];
            end
            2'd1:
            begin
                cos_out = -y_reg[STAGES-1];
                sin_out = x_reg[STAGES-1];
            end
            2'd2:
            begin
                cos_out = -x_reg[STAGES-1];
                sin_out = -y_reg[STAGES-1];
            end
            default:
            begin
                cos_out = y_reg[STAGES-1];
                sin_out = -x_reg[STAGES-1];
            end
        endcase
    end

endmodule

### rtl/uvs_out.sv
// Output register that splits a cell into one or two triangle transfers.
`timescale 1ns / 1ps

module uvs_out (
    input  logic              clk,
    input  logic              rst_n,
    input  uvs_pkg::out_ctl_t ctl,
    input  uvs_pkg::res_t     first,
    input  uvs_pkg::res_t     second,
    output logic              ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output uvs_pkg::res_t     m_res
);

    logic          vld_reg;
    logic          pend_reg;
    uvs_pkg::res_t res_reg;
    uvs_pkg::res_t sec_reg;
    logic          send_second;

    assign send_second = vld_reg && m_tready && pend_reg;
    assign ready       = !pend_reg && (!vld_reg || m_tready);

    // Track valid and a waiting second triangle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (send_second)
        begin
            pend_reg <= 1'b0;
        end
        else if (ready)
        begin
            vld_reg  <= ctl.valid;
            pend_reg <= ctl.valid && ctl.two;
        end
    end

    // Hold the result until transfer
    always_ff @(posedge clk)
    begin
        if (send_second)
        begin
            res_reg <= sec_reg;
        end
        else if (ready)
        begin
            res_reg <= first;
            sec_reg <= second;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_res    = res_reg;

endmodule

### rtl/uv_sphere_mesh_generator_top.sv
// Top level of the UV sphere mesh generator.
//
// Channel  Direction  Transfer                 Payload
// s_*      in         s_tvalid & s_tready      tdata: ring, sector; tuser: request kind
// m_*      out        m_tvalid & m_tready      tdata: vertex/triangle fields; tlast
// cfg_*    in         cfg_we                   cfg_addr selects radius, rings, sectors
//
// One request enters per cycle while the output is not stalled; a cell giving two
// triangles holds the input while the output register sends its second transfer.
// Requests pass the input register, the 40-step long divider (8 bits a stage), the
// angle register, CORDIC (4 steps a stage), and product, scale and output registers.
// A stall at m_tready freezes every stage at once; nothing is lost or repeated.
// Reset clears valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_top #(
    parameter int MAX_DIVISIONS = 255,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uvs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ring_index [7:0], sector_index [15:8]
    input  logic [uvs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type [0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, pos_z (17 each), norm_x, norm_y, norm_z, tex_s, tex_t,
    // tri_first, tri_second, tri_third (16 each), zero fill
    output logic [uvs_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int NW            = uvs_pkg::DIV_NUM_W;
    localparam int CORDIC_STAGES = (CORDIC_STEPS + uvs_pkg::CORDIC_PER_STAGE - 1)
                                   / uvs_pkg::CORDIC_PER_STAGE;
    localparam int SIDE_LEN      = uvs_pkg::DIV_STAGES + 3 + CORDIC_STAGES;
    localparam int TEX_LEN       = CORDIC_STAGES + 3;

    function automatic logic [7:0] eff_count(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (int'({24'd0, c}) > MAX_DIVISIONS)
        begin
            r = 8'(MAX_DIVISIONS);
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_norm(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic [15:0] r;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
            r = 16'd16384;
        else if (t < -34'sd16384)
            r = 16'hC000;
        else
            r = t[15:0];
        return r;
    endfunction

    function automatic logic [16:0] sat_pos(input logic signed [50:0] v);
        logic signed [50:0] t;
        logic [16:0] r;
        t = (v + 51'sd536870912) >>> 30;
        if (t > 51'sd65535)
            r = 17'h0FFFF;
        else if (t < -51'sd65536)
            r = 17'h10000;
        else
            r = t[16:0];
        return r;
    endfunction

    logic en;

    // Configuration registers
    logic [15:0] radius_reg;
    logic [7:0]  rings_reg;
    logic [7:0]  sectors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= uvs_pkg::RADIUS_RST;
            rings_reg   <= uvs_pkg::RINGS_RST;
            sectors_reg <= uvs_pkg::SECTORS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                uvs_pkg::REG_RADIUS:  radius_reg  <= cfg_wdata;
                uvs_pkg::REG_RINGS:   rings_reg   <= cfg_wdata[7:0];
                uvs_pkg::REG_SECTORS: sectors_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic [7:0] rings;
    logic [7:0] sectors;
    assign rings   = eff_count(rings_reg);
    assign sectors = eff_count(sectors_reg);

    // Input stage: range check, cell indices, divider numerators
    logic          kind;
    logic [7:0]    ring_i;
    logic [7:0]    sect_j;
    logic          item_ok;
    logic [16:0]   k1_full;
    logic [16:0]   k2_full;
    uvs_pkg::side_t side_next;

    assign kind   = s_tuser[0];
    assign ring_i = s_tdata[7:0];
    assign sect_j = s_tdata[15:8];

    always_comb
    begin
        k1_full = ({9'd0, ring_i} * ({9'd0, sectors} + 17'd1)) + {9'd0, sect_j};
        k2_full = k1_full + {9'd0, sectors} + 17'd1;
        side_next.kind     = kind;
        side_next.tri_a_en = (ring_i != 8'd0);
        side_next.tri_b_en = (ring_i != rings - 8'd1);
        side_next.k1       = k1_full[15:0];
        side_next.k2       = k2_full[15:0];
        if (rings == 8'd0 || sectors == 8'd0)
            item_ok = 1'b0;
        else if (kind == uvs_pkg::REQ_VERTEX)
            item_ok = (ring_i <= rings) && (sect_j <= sectors);
        else
            item_ok = (ring_i < rings) && (sect_j < sectors)
                      && (side_next.tri_a_en || side_next.tri_b_en);
    end

    logic           a_vld_reg;
    uvs_pkg::side_t a_side_reg;
    logic [NW-1:0]  a_nv_reg, a_nu_reg, a_ns_reg, a_nt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= s_tvalid && item_ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= side_next;
            a_nv_reg   <= {sect_j, 32'd0} + {32'd0, 1'b0, sectors[7:1]};
            a_nu_reg   <= {1'b0, ring_i, 31'd0} + {32'd0, 1'b0, rings[7:1]};
            a_ns_reg   <= {17'd0, sect_j, 15'd0} + {32'd0, 1'b0, sectors[7:1]};
            a_nt_reg   <= {17'd0, ring_i, 15'd0} + {32'd0, 1'b0, rings[7:1]};
        end
    end

    // Angle and texture divisions
    logic [NW-1:0] q_v, q_u, q_s, q_t;

    uvs_div u_div_v (.clk(clk), .en(en), .divisor(sectors), .num(a_nv_reg), .quot(q_v));
    uvs_div u_div_u (.clk(clk), .en(en), .divisor(rings),   .num(a_nu_reg), .quot(q_u));
    uvs_div u_div_s (.clk(clk), .en(en), .divisor(sectors), .num(a_ns_reg), .quot(q_s));
    uvs_div u_div_t (.clk(clk), .en(en), .divisor(rings),   .num(a_nt_reg), .quot(q_t));

    // Angle stage: latitude from the pole, longitude as is
    logic [31:0] au_reg, av_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            au_reg <= 32'h4000_0000 - q_u[31:0];
            av_reg <= q_v[31:0];
        end
    end

    logic signed [31:0] cu, su, cv, sv;

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_u (
        .clk(clk), .en(en), .phase(au_reg), .cos_out(cu), .sin_out(su)
    );
    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_v (
        .clk(clk), .en(en), .phase(av_reg), .cos_out(cv), .sin_out(sv)
    );

    // Direction products, rounded to Q4.30
    logic signed [33:0] px_reg, py_reg;
    logic signed [31:0] su_reg;
    logic signed [63:0] px_wide, py_wide;

    always_comb
    begin
        px_wide = (64'(cu) * 64'(cv)) + 64'sd536870912;
        py_wide = (64'(cu) * 64'(sv)) + 64'sd536870912;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 34'(px_wide >>> 30);
            py_reg <= 34'(py_wide >>> 30);
            su_reg <= su;
        end
    end

    // Scale by radius; round normals
    logic signed [50:0] rx_reg, ry_reg, rz_reg;
    logic [15:0]        nx_reg, ny_reg, nz_reg;
    logic signed [16:0] rad_s;

    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= 51'(rad_s) * 51'(px_reg);
            ry_reg <= 51'(rad_s) * 51'(py_reg);
            rz_reg <= 51'(rad_s) * 51'(su_reg);
            nx_reg <= sat_norm(px_reg);
            ny_reg <= sat_norm(py_reg);
            nz_reg <= sat_norm(34'(su_reg));
        end
    end

    // Side lines: request control and texture coordinates
    logic [SIDE_LEN-1:0] vld_reg;
    uvs_pkg::side_t      sd_reg [SIDE_LEN];
    uvs_pkg::tex_t       tx_reg [TEX_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SIDE_LEN-2:0], a_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0]       <= a_side_reg;
            tx_reg[0].tex_s <= q_s[15:0];
            tx_reg[0].tex_t <= q_t[15:0];
            for (int k = 1; k < SIDE_LEN; k++)
                sd_reg[k] <= sd_reg[k-1];
            for (int k = 1; k < TEX_LEN; k++)
                tx_reg[k] <= tx_reg[k-1];
        end
    end

    // Assemble results
    uvs_pkg::side_t    sd_end;
    uvs_pkg::out_ctl_t ctl;
    uvs_pkg::res_t     res_first, res_second;
    logic [15:0]       k1p, k2p;

    assign sd_end = sd_reg[SIDE_LEN-1];
    assign k1p    = sd_end.k1 + 16'd1;
    assign k2p    = sd_end.k2 + 16'd1;

    always_comb
    begin
        res_first  = '0;
        res_second = '0;
        ctl.valid  = vld_reg[SIDE_LEN-1];
        ctl.two    = 1'b0;
        if (sd_end.kind == uvs_pkg::REQ_VERTEX)
        begin
            res_first.pos_x  = sat_pos(rx_reg);
            res_first.pos_y  = sat_pos(ry_reg);
            res_first.pos_z  = sat_pos(rz_reg);
            res_first.norm_x = nx_reg;
            res_first.norm_y = ny_reg;
            res_first.norm_z = nz_reg;
            res_first.tex_s  = tx_reg[TEX_LEN-1].tex_s;
            res_first.tex_t  = tx_reg[TEX_LEN-1].tex_t;
            res_first.last   = 1'b1;
        end
        else
        begin
            ctl.two                = sd_end.tri_a_en && sd_end.tri_b_en;
            res_second.tri_first   = k1p;
            res_second.tri_second  = sd_end.k2;
            res_second.tri_third   = k2p;
            res_second.last        = 1'b1;
            if (sd_end.tri_a_en)
            begin
                res_first.tri_first  = sd_end.k1;
                res_first.tri_second = sd_end.k2;
                res_first.tri_third  = k1p;
                res_first.last       = !ctl.two;
            end
            else
            begin
                res_first = res_second;
            end
        end
    end

    uvs_pkg::res_t m_res;

    uvs_out u_out (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .first(res_first), .second(res_second),
        .ready(en), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(m_res)
    );

    assign s_tready = en;
    assign m_tlast  = m_res.last;
    assign m_tdata  = {5'd0, m_res.tri_third, m_res.tri_second, m_res.tri_first,
                       m_res.tex_t, m_res.tex_s, m_res.norm_z, m_res.norm_y,
                       m_res.norm_x, m_res.pos_z, m_res.pos_y, m_res.pos_x};

endmodule

### rtl/uvs_checker.sv
// Port-level checks of the UV sphere generator, bound to the top level.
`timescale 1ns / 1ps
`include "uv_sphere_mesh_generator_top_assert.svh"

module uvs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [uvs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // Hold a stalled result
    `UVS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A non-final result is a triangle, so it carries no position
    `UVS_ASSERT_NOW(a_tri_no_pos, m_tvalid && !m_tlast, m_tdata[50:0] == 51'd0)

    // The second triangle follows its first without a gap
    `UVS_ASSERT_NEXT(a_pair_back, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // The x normal stays within unit range
    `UVS_ASSERT_NOW(a_norm_range, m_tvalid,
        $signed(m_tdata[66:51]) <= 16'sd16384 && $signed(m_tdata[66:51]) >= -16'sd16384)

endmodule

bind uv_sphere_mesh_generator_top uvs_checker u_uvs_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

### sim/tb_uv_sphere_mesh_generator_top.sv
// Testbench for the UV sphere mesh generator: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_uv_sphere_mesh_generator_top;

    localparam int PIPE_WAIT = 40;
    localparam int QUIET_TAIL = 150;
    localparam int HOLD_CYCLES = 200;

    // Arctangent of 2^-k in binary turns for the sine/cosine rotation
    localparam longint ROT_ANGLE [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic        kind;
        logic [7:0]  ring;
        logic [7:0]  sector;
        bit          typed;
        int          n_tri;
        logic [15:0] t0 [3];
        logic [15:0] t1 [3];
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [uvs_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [uvs_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [uvs_pkg::IN_TDATA_W-1:0] s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [uvs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    // Mirror of the block's registers
    logic [15:0] radius_q;
    logic [7:0]  rings_q;
    logic [7:0]  sectors_q;

    uvs_pkg::res_t mesh_q [$];
    int   err_cnt;
    bit   quiet;
    bit   hold_req;

    uv_sphere_mesh_generator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("uv_sphere_mesh_generator_top: mismatch");
        $finish;
    end

    function automatic longint round_sh(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void expect_res(uvs_pkg::res_t r);
        mesh_q.insert(mesh_q.size(), r);
    endfunction

    // Rotate the gain-corrected unit vector to the angle, then restore the quadrant
    function automatic void sin_cos(input logic [31:0] phase, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int k = 0; k < 16; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ROT_ANGLE[k];
            end
            else
            begin
                x += dx; y -= dy; z += ROT_ANGLE[k];
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic uvs_pkg::res_t tri_res(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] c, logic lst);
        uvs_pkg::res_t r;
        r = '0;
        r.tri_first = a;
        r.tri_second = b;
        r.tri_third = c;
        r.last = lst;
        return r;
    endfunction

    // Queue the vertex or triangles that one request yields
    task automatic predict_mesh(logic kind, logic [7:0] i, logic [7:0] j);
        longint rings, sectors, pu, pv, cu, su, cv, sv, px, py, r;
        logic [31:0] au;
        logic [31:0] k1, k2;
        uvs_pkg::res_t v;
        bit first_tri, second_tri;
        rings = rings_q;
        sectors = sectors_q;
        r = radius_q;
        if (rings == 0 || sectors == 0)
            return;
        if (kind == uvs_pkg::REQ_VERTEX)
        begin
            if (i > rings || j > sectors)
                return;
            pv = ((longint'(j) << 32) + sectors / 2) / sectors;
            pu = ((longint'(i) << 31) + rings / 2) / rings;
            au = 32'h4000_0000 - pu[31:0];
            sin_cos(au, cu, su);
            sin_cos(pv[31:0], cv, sv);
            px = round_sh(cu * cv, 30);
            py = round_sh(cu * sv, 30);
            v = '0;
            v.pos_x = 17'(clip(round_sh(r * px, 30), -65536, 65535));
            v.pos_y = 17'(clip(round_sh(r * py, 30), -65536, 65535));
            v.pos_z = 17'(clip(round_sh(r * su, 30), -65536, 65535));
            v.norm_x = 16'(clip(round_sh(px, 16), -16384, 16384));
            v.norm_y = 16'(clip(round_sh(py, 16), -16384, 16384));
            v.norm_z = 16'(clip(round_sh(su, 16), -16384, 16384));
            v.tex_s = 16'((longint'(j) * 32768 + sectors / 2) / sectors);
            v.tex_t = 16'((longint'(i) * 32768 + rings / 2) / rings);
            v.last = 1'b1;
            expect_res(v);
        end
        else
        begin
            if (i >= rings || j >= sectors)
                return;
            k1 = 32'(longint'(i) * (sectors + 1) + longint'(j));
            k2 = 32'(longint'(k1) + sectors + 1);
            first_tri = (i != 0);
            second_tri = (i != rings - 1);
            if (first_tri)
                expect_res(tri_res(k1[15:0], k2[15:0], k1[15:0] + 16'd1, !second_tri));
            if (second_tri)
                expect_res(tri_res(k1[15:0] + 16'd1, k2[15:0], k2[15:0] + 16'd1, 1'b1));
        end
    endtask

    task automatic chk(string nm, longint e, longint a);
        if (e != a)
        begin
            $error("%s: expected %0h, got %0h", nm, e, a);
            err_cnt++;
        end
    endtask

    // Output side: compare each transfer, stall in random bursts or on a hold request
    initial
    begin
        int stall_left;
        uvs_pkg::res_t e;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (mesh_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    err_cnt++;
                end
                else
                begin
                    e = mesh_q.pop_front();
                    chk("pos_x", e.pos_x, m_tdata[16:0]);
                    chk("pos_y", e.pos_y, m_tdata[33:17]);
                    chk("pos_z", e.pos_z, m_tdata[50:34]);
                    chk("norm_x", e.norm_x, m_tdata[66:51]);
                    chk("norm_y", e.norm_y, m_tdata[82:67]);
                    chk("norm_z", e.norm_z, m_tdata[98:83]);
                    chk("tex_s", e.tex_s, m_tdata[114:99]);
                    chk("tex_t", e.tex_t, m_tdata[130:115]);
                    chk("tri_first", e.tri_first, m_tdata[146:131]);
                    chk("tri_second", e.tri_second, m_tdata[162:147]);
                    chk("tri_third", e.tri_third, m_tdata[178:163]);
                    chk("last", e.last, m_tlast);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_req(logic kind, logic [7:0] i, logic [7:0] j);
        s_tvalid <= 1'b1;
        s_tdata <= {j, i};
        s_tuser <= kind;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic gap_maybe();
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mesh_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    // Write one register, then leave the port idle before returning
    task automatic write_reg(logic [uvs_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            uvs_pkg::REG_RADIUS:  radius_q = val;
            uvs_pkg::REG_RINGS:   rings_q = val[7:0];
            uvs_pkg::REG_SECTORS: sectors_q = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Random phase: mostly well-formed grid requests, some full-range noise
    task automatic run_phase(int n_items, bit hold_at_start, int pause_at, bit last_phase);
        logic kind;
        logic [7:0] i, j;
        for (int n = 0; n < n_items; n++)
        begin
            if (last_phase && n == n_items - QUIET_TAIL)
                quiet = 1'b1;
            if (hold_at_start && n == 0)
                hold_req = 1'b1;
            if (n == pause_at)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (mesh_q.size() != 0)
                    @(posedge clk);
            end
            kind = 1'($urandom_range(0, 1));
            if (rings_q == 0 || sectors_q == 0 || $urandom_range(0, 6) == 0)
            begin
                i = 8'($urandom_range(0, 255));
                j = 8'($urandom_range(0, 255));
            end
            else
            begin
                i = 8'($urandom_range(0, rings_q));
                j = 8'($urandom_range(0, sectors_q));
            end
            send_req(kind, i, j);
            predict_mesh(kind, i, j);
            gap_maybe();
        end
        drain();
    endtask

    dir_row_t dir_tab [12];

    initial
    begin
        err_cnt = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        radius_q = uvs_pkg::RADIUS_RST;
        rings_q = uvs_pkg::RINGS_RST;
        sectors_q = uvs_pkg::SECTORS_RST;

        // Reset defaults: 16 rings, 32 sectors, 33 vertices per ring
        dir_tab[0]  = '{uvs_pkg::REQ_CELL, 0, 0, 1, 1, '{1, 33, 34}, '{0, 0, 0}};
        dir_tab[1]  = '{uvs_pkg::REQ_CELL, 15, 31, 1, 1, '{526, 559, 527}, '{0, 0, 0}};
        dir_tab[2]  = '{uvs_pkg::REQ_CELL, 1, 0, 1, 2, '{33, 66, 34}, '{34, 66, 67}};
        dir_tab[3]  = '{uvs_pkg::REQ_CELL, 16, 0, 1, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[4]  = '{uvs_pkg::REQ_CELL, 255, 255, 1, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[5]  = '{uvs_pkg::REQ_VERTEX, 17, 0, 1, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[6]  = '{uvs_pkg::REQ_VERTEX, 0, 33, 1, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[7]  = '{uvs_pkg::REQ_VERTEX, 255, 255, 1, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[8]  = '{uvs_pkg::REQ_VERTEX, 0, 0, 0, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[9]  = '{uvs_pkg::REQ_VERTEX, 16, 32, 0, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[10] = '{uvs_pkg::REQ_VERTEX, 8, 16, 0, 0, '{0, 0, 0}, '{0, 0, 0}};
        dir_tab[11] = '{uvs_pkg::REQ_CELL, 7, 20, 0, 0, '{0, 0, 0}, '{0, 0, 0}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, typed expectations where obvious
        foreach (dir_tab[r])
        begin
            send_req(dir_tab[r].kind, dir_tab[r].ring, dir_tab[r].sector);
            if (dir_tab[r].typed)
            begin
                if (dir_tab[r].n_tri == 1)
                    expect_res(tri_res(dir_tab[r].t0[0], dir_tab[r].t0[1],
                                       dir_tab[r].t0[2], 1'b1));
                else if (dir_tab[r].n_tri == 2)
                begin
                    expect_res(tri_res(dir_tab[r].t0[0], dir_tab[r].t0[1],
                                       dir_tab[r].t0[2], 1'b0));
                    expect_res(tri_res(dir_tab[r].t1[0], dir_tab[r].t1[1],
                                       dir_tab[r].t1[2], 1'b1));
                end
            end
            else
                predict_mesh(dir_tab[r].kind, dir_tab[r].ring, dir_tab[r].sector);
        end
        drain();

        // Largest grid and radius: positions clamp
        write_reg(uvs_pkg::REG_RADIUS, 16'hFFFF);
        write_reg(uvs_pkg::REG_RINGS, 16'd255);
        write_reg(uvs_pkg::REG_SECTORS, 16'd255);
        run_phase(300, 1'b1, -1, 1'b0);

        // Single ring and sector: cells give nothing
        write_reg(uvs_pkg::REG_RADIUS, 16'd1);
        write_reg(uvs_pkg::REG_RINGS, 16'd1);
        write_reg(uvs_pkg::REG_SECTORS, 16'd1);
        run_phase(80, 1'b0, -1, 1'b0);

        // Zero radius, small grid, mid-phase pause
        write_reg(uvs_pkg::REG_RADIUS, 16'd0);
        write_reg(uvs_pkg::REG_RINGS, 16'd2);
        write_reg(uvs_pkg::REG_SECTORS, 16'd3);
        run_phase(120, 1'b0, 50, 1'b0);

        // Zero counts give no result at all
        write_reg(uvs_pkg::REG_RADIUS, 16'd300);
        write_reg(uvs_pkg::REG_RINGS, 16'd0);
        run_phase(40, 1'b0, -1, 1'b0);
        write_reg(uvs_pkg::REG_RINGS, 16'd8);
        write_reg(uvs_pkg::REG_SECTORS, 16'd0);
        run_phase(40, 1'b0, -1, 1'b0);

        // Random settings
        write_reg(uvs_pkg::REG_RADIUS, 16'($urandom_range(1, 65535)));
        write_reg(uvs_pkg::REG_RINGS, 16'($urandom_range(1, 255)));
        write_reg(uvs_pkg::REG_SECTORS, 16'($urandom_range(1, 255)));
        run_phase(300, 1'b0, -1, 1'b0);

        write_reg(uvs_pkg::REG_RADIUS, 16'($urandom_range(1, 2048)));
        write_reg(uvs_pkg::REG_RINGS, 16'($urandom_range(2, 40)));
        write_reg(uvs_pkg::REG_SECTORS, 16'($urandom_range(2, 40)));
        run_phase(360, 1'b0, -1, 1'b1);

        if (err_cnt == 0)
            $display("uv_sphere_mesh_generator_top: match");
        else
            $display("uv_sphere_mesh_generator_top: mismatch");
        $finish;
    end

endmodule
